@@ rtl/ssrpg_pkg.sv @@
package ssrpg_pkg;

    // screen and sprite geometry
    localparam int GRID_COLS = 64;
    localparam int GRID_ROWS = 16;
    localparam int SPR_H     = 7;
    localparam int SPR_W     = 7;
    localparam int ROW_W     = 36;
    localparam int N_ELEM    = 9;
    localparam int BAND_ROW  = (GRID_ROWS - SPR_H) / 2;
    localparam int DOT_ROW   = BAND_ROW + SPR_H / 2;
    localparam int DOT_COL   = 1;

    localparam int COL_W    = 6;
    localparam int ROWIDX_W = 4;
    localparam int OFS_W    = 6;
    localparam int ELEM_W_B = 4;
    localparam int COLOR_W  = 24;
    localparam int CFG_IDX_W = 4;

    // request kinds carried on the input tuser
    typedef enum logic {
        REQ_QUERY = 1'b0,
        REQ_TICK  = 1'b1
    } req_type_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE          = 4'd0,
        CFG_SCROLL_PERIOD = 4'd1,
        CFG_ANIM_PERIOD   = 4'd2,
        CFG_MONO_COLOR    = 4'd3,
        CFG_CHOMPER_COLOR = 4'd4,
        CFG_GHOST_A_COLOR = 4'd5,
        CFG_GHOST_B_COLOR = 4'd6,
        CFG_DOT_COLOR     = 4'd7
    } cfg_index_t;

    // mode register bits
    localparam int MODE_COLOR_BIT   = 0;
    localparam int MODE_REVERSE_BIT = 1;

    // element kinds along the row
    typedef enum logic [1:0] {
        KIND_CHOMPER = 2'd0,
        KIND_GAP     = 2'd1,
        KIND_DOT     = 2'd2,
        KIND_GHOST   = 2'd3
    } kind_t;

    localparam logic [ELEM_W_B-1:0] GHOST_A_ELEM = 4'd5;

    typedef logic [5:0] elem_width_arr_t [N_ELEM];
    typedef kind_t elem_kind_arr_t [N_ELEM];
    typedef logic [SPR_W-1:0] sprite_t [2][SPR_H];

    localparam elem_width_arr_t ELEM_WIDTH = '{
        6'd7, 6'd2, 6'd3, 6'd3, 6'd3, 6'd7, 6'd2, 6'd7, 6'd2
    };
    localparam elem_kind_arr_t ELEM_KIND = '{
        KIND_CHOMPER, KIND_GAP, KIND_DOT, KIND_DOT, KIND_DOT,
        KIND_GHOST, KIND_GAP, KIND_GHOST, KIND_GAP
    };

    localparam sprite_t CHOMPER_SPR = '{
        '{7'h1C, 7'h3E, 7'h7C, 7'h70, 7'h7C, 7'h3E, 7'h1C},
        '{7'h1C, 7'h3E, 7'h7E, 7'h7F, 7'h7E, 7'h3E, 7'h1C}
    };
    localparam sprite_t GHOST_SPR = '{
        '{7'h1C, 7'h3E, 7'h6B, 7'h7F, 7'h7F, 7'h7F, 7'h55},
        '{7'h1C, 7'h3E, 7'h6B, 7'h7F, 7'h7F, 7'h7F, 7'h2A}
    };

    // colour set handed to the pixel lookup
    typedef struct packed {
        logic               colored;
        logic [COLOR_W-1:0] mono;
        logic [COLOR_W-1:0] chomper;
        logic [COLOR_W-1:0] ghost_a;
        logic [COLOR_W-1:0] ghost_b;
        logic [COLOR_W-1:0] dot;
    } palette_t;

    typedef struct packed {
        logic                found;
        logic [ELEM_W_B-1:0] elem;
        logic [2:0]          local_col;
    } elem_hit_t;

    // compare the pattern column against each element's fixed span in parallel
    function automatic elem_hit_t find_elem(logic [5:0] pc);
        elem_hit_t hit;
        int        start;
        hit   = '0;
        start = 0;
        for (int i = 0; i < N_ELEM; i++) begin
            if (pc >= 6'(start) && pc < 6'(start + int'(ELEM_WIDTH[i]))) begin
                hit.found     = 1'b1;
                hit.elem      = ELEM_W_B'(i);
                hit.local_col = 3'(pc - 6'(start));
            end
            start = start + int'(ELEM_WIDTH[i]);
        end
        return hit;
    endfunction

endpackage

@@ rtl/ssrpg_pixel.sv @@
module ssrpg_pixel
    import ssrpg_pkg::*;
(
    input  logic [COL_W-1:0]    column,
    input  logic [ROWIDX_W-1:0] row,
    input  logic [OFS_W-1:0]    scroll_offset,
    input  logic                anim_frame,
    input  palette_t            palette,
    output logic                lit,
    output logic [COLOR_W-1:0]  color
);

    logic [6:0]          sum;
    logic [5:0]          pc;
    elem_hit_t           hit;
    kind_t               kind;
    logic                in_grid;
    logic                in_band;
    logic [2:0]          spr_row;
    logic [SPR_W-1:0]    bits;
    logic [COLOR_W-1:0]  own;

    // pattern column modulo row width
    assign sum = {1'b0, column} + {1'b0, scroll_offset};

    always_comb
    begin
        if (sum >= 7'(2 * ROW_W))
            pc = 6'(sum - 7'(2 * ROW_W));
        else if (sum >= 7'(ROW_W))
            pc = 6'(sum - 7'(ROW_W));
        else
            pc = sum[5:0];
    end

    assign hit     = find_elem(pc);
    assign in_grid = (int'(column) < GRID_COLS) && (int'(row) < GRID_ROWS);
    assign in_band = (int'(row) >= BAND_ROW) && (int'(row) < BAND_ROW + SPR_H);
    assign spr_row = 3'(row - ROWIDX_W'(BAND_ROW));

    // sprite row and element colour
    always_comb
    begin
        kind = KIND_GAP;
        bits = '0;
        own  = palette.chomper;
        if (hit.found && int'(hit.elem) < N_ELEM)
            kind = ELEM_KIND[hit.elem];
        if (in_band && int'(spr_row) < SPR_H) begin
            case (kind)
                KIND_CHOMPER: begin
                    bits = CHOMPER_SPR[anim_frame][spr_row];
                    own  = palette.chomper;
                end
                KIND_GHOST: begin
                    bits = GHOST_SPR[anim_frame][spr_row];
                    own  = (hit.elem == GHOST_A_ELEM) ? palette.ghost_a : palette.ghost_b;
                end
                default: begin
                    bits = '0;
                    own  = palette.chomper;
                end
            endcase
        end
    end

    // lit decision and colour select
    always_comb
    begin
        lit   = 1'b0;
        color = '0;
        if (in_grid) begin
            if (kind == KIND_DOT) begin
                if (int'(hit.local_col) == DOT_COL && int'(row) == DOT_ROW) begin
                    lit   = 1'b1;
                    color = palette.colored ? palette.dot : palette.mono;
                end
            end
            else if (kind != KIND_GAP && in_band && int'(hit.local_col) < SPR_W) begin
                if (bits[3'(SPR_W - 1) - hit.local_col]) begin
                    lit   = 1'b1;
                    color = palette.colored ? own : palette.mono;
                end
            end
        end
    end

endmodule

@@ rtl/scrolling_sprite_row_pixel_gen_unit.sv @@
// channel   direction  word contents (lowest bit first)
// s_axis    in         tdata: column[5:0], row[9:6]; tuser: req_type (1 = tick)
// m_axis    out        tdata: red[7:0], green[15:8], blue[23:16]; tuser: lit
// cfg       in         cfg_index selects register, cfg_data[23:0] is written
//
// one word per cycle sustained while the result channel is not stalled; a query
// result passes the input register, then the result register via the sprite lookup
// a tick leaves no result word; it updates the scroll and animation counters
// as it leaves the input register, so later queries see the new state
// rst_n clears all control state and loads the register defaults
// a stalled result register holds the input register, which still takes a
// word if it is empty or holds a tick
module scrolling_sprite_row_pixel_gen_unit
    import ssrpg_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [15:0]          s_axis_tdata,   // column[5:0], row[9:6], zero fill
    input  logic                 s_axis_tuser,   // req_type
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [23:0]          m_axis_tdata,   // red[7:0], green[15:8], blue[23:16]
    output logic                 m_axis_tuser,   // lit
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [23:0]          cfg_data
);

    // configuration registers
    logic [1:0]         mode_reg;
    logic [7:0]         scroll_period_reg;
    logic [7:0]         anim_period_reg;
    logic [COLOR_W-1:0] mono_color_reg;
    logic [COLOR_W-1:0] chomper_color_reg;
    logic [COLOR_W-1:0] ghost_a_color_reg;
    logic [COLOR_W-1:0] ghost_b_color_reg;
    logic [COLOR_W-1:0] dot_color_reg;

    // scroll and animation state
    logic [OFS_W-1:0]   scroll_offset_reg;
    logic [OFS_W-1:0]   scroll_offset_next;
    logic [7:0]         scroll_count_reg;
    logic [7:0]         scroll_count_next;
    logic [7:0]         anim_count_reg;
    logic [7:0]         anim_count_next;
    logic               anim_frame_reg;
    logic               anim_frame_next;

    // input register
    logic                in_valid_reg;
    req_type_t           in_type_reg;
    logic [COL_W-1:0]    in_col_reg;
    logic [ROWIDX_W-1:0] in_row_reg;

    // result register
    logic               out_valid_reg;
    logic               out_lit_reg;
    logic [COLOR_W-1:0] out_color_reg;

    logic               in_advance;
    logic               do_tick;
    logic               do_query;
    logic               s_accept;
    logic               pix_lit;
    logic [COLOR_W-1:0] pix_color;
    palette_t           palette;
    logic [7:0]         scroll_inc;
    logic [7:0]         anim_inc;

    // handshake
    assign in_advance    = !in_valid_reg || (in_type_reg == REQ_TICK)
                           || !out_valid_reg || m_axis_tready;
    assign s_axis_tready = in_advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign do_tick       = in_valid_reg && (in_type_reg == REQ_TICK);
    assign do_query      = in_valid_reg && (in_type_reg == REQ_QUERY) && in_advance;
    assign cfg_ready     = 1'b1;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg          <= 2'd0;
            scroll_period_reg <= 8'd4;
            anim_period_reg   <= 8'd1;
            mono_color_reg    <= 24'h00FF00;
            chomper_color_reg <= 24'hFFFF55;
            ghost_a_color_reg <= 24'hFF5555;
            ghost_b_color_reg <= 24'h55FFFF;
            dot_color_reg     <= 24'hFFB950;
        end
        else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_MODE:          mode_reg          <= cfg_data[1:0];
                CFG_SCROLL_PERIOD: scroll_period_reg <= cfg_data[7:0];
                CFG_ANIM_PERIOD:   anim_period_reg   <= cfg_data[7:0];
                CFG_MONO_COLOR:    mono_color_reg    <= cfg_data;
                CFG_CHOMPER_COLOR: chomper_color_reg <= cfg_data;
                CFG_GHOST_A_COLOR: ghost_a_color_reg <= cfg_data;
                CFG_GHOST_B_COLOR: ghost_b_color_reg <= cfg_data;
                CFG_DOT_COLOR:     dot_color_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    // tick: scroll step and frame toggle
    assign scroll_inc = scroll_count_reg + 8'd1;
    assign anim_inc   = anim_count_reg + 8'd1;

    always_comb
    begin
        scroll_count_next  = scroll_inc;
        scroll_offset_next = scroll_offset_reg;
        if (scroll_inc >= scroll_period_reg || scroll_inc == 8'd0) begin
            scroll_count_next = 8'd0;
            if (mode_reg[MODE_REVERSE_BIT])
                scroll_offset_next = (scroll_offset_reg == '0) ? OFS_W'(ROW_W - 1)
                                                               : scroll_offset_reg - 6'd1;
            else
                scroll_offset_next = (scroll_offset_reg >= OFS_W'(ROW_W - 1)) ? '0
                                                               : scroll_offset_reg + 6'd1;
        end
        anim_count_next = anim_inc;
        anim_frame_next = anim_frame_reg;
        if (anim_inc >= anim_period_reg || anim_inc == 8'd0) begin
            anim_count_next = 8'd0;
            anim_frame_next = !anim_frame_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            scroll_offset_reg <= '0;
            scroll_count_reg  <= '0;
            anim_count_reg    <= '0;
            anim_frame_reg    <= 1'b0;
        end
        else if (do_tick) begin
            scroll_offset_reg <= scroll_offset_next;
            scroll_count_reg  <= scroll_count_next;
            anim_count_reg    <= anim_count_next;
            anim_frame_reg    <= anim_frame_next;
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_advance)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_accept) begin
            in_type_reg <= req_type_t'(s_axis_tuser);
            in_col_reg  <= s_axis_tdata[5:0];
            in_row_reg  <= s_axis_tdata[9:6];
        end
    end

    // sprite lookup
    assign palette = '{
        colored: mode_reg[MODE_COLOR_BIT],
        mono:    mono_color_reg,
        chomper: chomper_color_reg,
        ghost_a: ghost_a_color_reg,
        ghost_b: ghost_b_color_reg,
        dot:     dot_color_reg
    };

    ssrpg_pixel u_pixel (
        .column        (in_col_reg),
        .row           (in_row_reg),
        .scroll_offset (scroll_offset_reg),
        .anim_frame    (anim_frame_reg),
        .palette       (palette),
        .lit           (pix_lit),
        .color         (pix_color)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (do_query)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (do_query) begin
            out_lit_reg   <= pix_lit;
            out_color_reg <= pix_color;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_lit_reg;
    assign m_axis_tdata  = {out_color_reg[7:0], out_color_reg[15:8], out_color_reg[23:16]};

`ifndef SYNTHESIS
    // offset always inside the row pattern
    a_offset_range: assert property (@(posedge clk) disable iff (!rst_n)
        scroll_offset_reg < OFS_W'(ROW_W))
        else $error("scroll offset out of range");

    // offset moves only on a tick
    a_offset_only_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
        !do_tick |=> $stable(scroll_offset_reg))
        else $error("scroll offset changed without a tick");

    // a tick never raises a result word
    a_tick_no_word: assert property (@(posedge clk) disable iff (!rst_n)
        (do_tick && !out_valid_reg) |=> !m_axis_tvalid)
        else $error("tick produced a result word");

    // unlit pixels carry a zero colour
    a_unlit_black: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("unlit pixel with non-zero colour");
`endif

endmodule

@@ tb/pixel_word_checker.sv @@
module pixel_word_checker
    import ssrpg_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    input  logic                 s_axis_tready,
    input  logic [15:0]          s_axis_tdata,   // column[5:0], row[9:6], zero fill
    input  logic                 s_axis_tuser,   // req_type
    input  logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    input  logic [23:0]          m_axis_tdata,   // red[7:0], green[15:8], blue[23:16]
    input  logic                 m_axis_tuser,   // lit
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [23:0]          cfg_data,
    output int                   mismatch_count,
    output int                   words_pending
);

    // repeating row layout: chomper 0..6, gap 7..8, dots 9..17 (three cells of
    // three), first ghost 18..24, gap 25..26, second ghost 27..33, gap 34..35
    localparam int PATTERN_W   = 36;
    localparam int SPRITE_ROWS = 7;
    localparam int SPRITE_TOP  = (GRID_ROWS - SPRITE_ROWS) / 2;
    localparam int DOTS_START  = 9;
    localparam int DOT_CELL    = 3;
    localparam int GHOST_A_AT  = 18;
    localparam int GHOST_B_AT  = 27;
    localparam int REPORT_MAX  = 10;

    typedef struct packed {
        logic       lit;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_word_t;

    pixel_word_t expected_pixels[$];

    // predicted registers and animation state
    logic [1:0]  mode_reg;
    logic [7:0]  scroll_period;
    logic [7:0]  anim_period;
    logic [23:0] mono_colour;
    logic [23:0] chomper_colour;
    logic [23:0] ghost_a_colour;
    logic [23:0] ghost_b_colour;
    logic [23:0] dot_colour;
    logic [5:0]  scroll_ofs;
    logic [7:0]  scroll_cnt;
    logic [7:0]  anim_cnt;
    logic        anim_frame;

    // sprite row bitmaps, leftmost pixel in bit 6
    function automatic logic [6:0] chomper_line(logic frame, logic [2:0] r);
        case (r)
            3'd0, 3'd6: return 7'h1C;
            3'd1, 3'd5: return 7'h3E;
            3'd3:       return frame ? 7'h7F : 7'h70;
            default:    return frame ? 7'h7E : 7'h7C;
        endcase
    endfunction

    function automatic logic [6:0] ghost_line(logic frame, logic [2:0] r);
        case (r)
            3'd0:    return 7'h1C;
            3'd1:    return 7'h3E;
            3'd2:    return 7'h6B;
            3'd6:    return frame ? 7'h2A : 7'h55;
            default: return 7'h7F;
        endcase
    endfunction

    // expected word for a pixel at the current scroll and frame
    function automatic pixel_word_t render_pixel(logic [5:0] col, logic [3:0] row);
        pixel_word_t px;
        int          pc;
        int          lc;
        int          band_r;
        kind_t       kind;
        logic [6:0]  line;
        logic [23:0] own;
        logic [23:0] colour;
        logic        lit;
        lit    = 1'b0;
        colour = '0;
        own    = '0;
        lc     = 0;
        kind   = KIND_GAP;
        pc     = (int'(col) + int'(scroll_ofs)) % PATTERN_W;
        band_r = int'(row) - SPRITE_TOP;
        if (pc < SPRITE_ROWS) begin
            kind = KIND_CHOMPER;
            lc   = pc;
            own  = chomper_colour;
        end
        else if (pc >= DOTS_START && pc < DOTS_START + 3 * DOT_CELL) begin
            kind = KIND_DOT;
            lc   = (pc - DOTS_START) % DOT_CELL;
        end
        else if (pc >= GHOST_A_AT && pc < GHOST_A_AT + SPRITE_ROWS) begin
            kind = KIND_GHOST;
            lc   = pc - GHOST_A_AT;
            own  = ghost_a_colour;
        end
        else if (pc >= GHOST_B_AT && pc < GHOST_B_AT + SPRITE_ROWS) begin
            kind = KIND_GHOST;
            lc   = pc - GHOST_B_AT;
            own  = ghost_b_colour;
        end
        if (int'(col) < GRID_COLS && int'(row) < GRID_ROWS) begin
            case (kind)
                KIND_DOT:
                begin
                    // a dot is the centre pixel of its cell on the middle band row
                    if (lc == 1 && band_r == SPRITE_ROWS / 2) begin
                        lit    = 1'b1;
                        colour = dot_colour;
                    end
                end
                KIND_CHOMPER, KIND_GHOST:
                begin
                    if (band_r >= 0 && band_r < SPRITE_ROWS) begin
                        line = (kind == KIND_CHOMPER) ? chomper_line(anim_frame, 3'(band_r))
                                                      : ghost_line(anim_frame, 3'(band_r));
                        if (line[6 - lc]) begin
                            lit    = 1'b1;
                            colour = own;
                        end
                    end
                end
                default: ;
            endcase
        end
        if (lit && !mode_reg[MODE_COLOR_BIT])
            colour = mono_colour;
        px.lit   = lit;
        px.red   = colour[23:16];
        px.green = colour[15:8];
        px.blue  = colour[7:0];
        return px;
    endfunction

    // frame tick: scroll step and animation toggle, each on its own period
    task automatic advance_frame();
        scroll_cnt = scroll_cnt + 8'd1;
        if (scroll_cnt >= scroll_period || scroll_cnt == 8'd0) begin
            scroll_cnt = '0;
            if (mode_reg[MODE_REVERSE_BIT])
                scroll_ofs = (scroll_ofs == 6'd0) ? 6'(PATTERN_W - 1) : scroll_ofs - 6'd1;
            else
                scroll_ofs = (int'(scroll_ofs) + 1 >= PATTERN_W) ? 6'd0 : scroll_ofs + 6'd1;
        end
        anim_cnt = anim_cnt + 8'd1;
        if (anim_cnt >= anim_period || anim_cnt == 8'd0) begin
            anim_cnt   = '0;
            anim_frame = ~anim_frame;
        end
    endtask

    // watch all three channels at each edge
    always @(posedge clk or negedge rst_n)
    begin : watch
        pixel_word_t got;
        pixel_word_t want;
        if (!rst_n) begin
            mode_reg       = '0;
            scroll_period  = 8'd4;
            anim_period    = 8'd1;
            mono_colour    = 24'h00FF00;
            chomper_colour = 24'hFFFF55;
            ghost_a_colour = 24'hFF5555;
            ghost_b_colour = 24'h55FFFF;
            dot_colour     = 24'hFFB950;
            scroll_ofs     = '0;
            scroll_cnt     = '0;
            anim_cnt       = '0;
            anim_frame     = 1'b0;
            mismatch_count = 0;
            expected_pixels.delete();
            words_pending  = 0;
        end
        else begin
            // register writes
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_MODE:          mode_reg       = cfg_data[1:0];
                    CFG_SCROLL_PERIOD: scroll_period  = cfg_data[7:0];
                    CFG_ANIM_PERIOD:   anim_period    = cfg_data[7:0];
                    CFG_MONO_COLOR:    mono_colour    = cfg_data;
                    CFG_CHOMPER_COLOR: chomper_colour = cfg_data;
                    CFG_GHOST_A_COLOR: ghost_a_colour = cfg_data;
                    CFG_GHOST_B_COLOR: ghost_b_colour = cfg_data;
                    CFG_DOT_COLOR:     dot_colour     = cfg_data;
                    default: ;
                endcase
            end

            // result words against the oldest expectation
            if (m_axis_tvalid && m_axis_tready) begin
                got.lit   = m_axis_tuser;
                got.red   = m_axis_tdata[7:0];
                got.green = m_axis_tdata[15:8];
                got.blue  = m_axis_tdata[23:16];
                if (expected_pixels.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display("ERROR: unexpected pixel word lit=%0b rgb=%02h%02h%02h",
                                 got.lit, got.red, got.green, got.blue);
                end
                else begin
                    want = expected_pixels.pop_front();
                    if (got.lit !== want.lit || got.red !== want.red ||
                        got.green !== want.green || got.blue !== want.blue) begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_MAX)
                            $display({"ERROR: pixel word differs: expected lit=%0b ",
                                      "rgb=%02h%02h%02h, got lit=%0b rgb=%02h%02h%02h"},
                                     want.lit, want.red, want.green, want.blue,
                                     got.lit, got.red, got.green, got.blue);
                    end
                end
            end

            // accepted input words
            if (s_axis_tvalid && s_axis_tready) begin
                if (s_axis_tuser == REQ_TICK)
                    advance_frame();
                else
                    expected_pixels.push_back(render_pixel(s_axis_tdata[5:0],
                                                           s_axis_tdata[9:6]));
            end
            words_pending = expected_pixels.size();
        end
    end

endmodule

@@ tb/scrolling_sprite_row_pixel_gen_unit_test.sv @@
module scrolling_sprite_row_pixel_gen_unit_test;
    import ssrpg_pkg::*;

    localparam int REG_COUNT  = 8;
    localparam int BAND_TOP   = (GRID_ROWS - SPR_H) / 2;
    localparam int HOLD_OFF   = 150;
    localparam int RAND_WORDS = 250;
    localparam int RAND_PASSES = 6;

    typedef enum int {
        FLOW_OPEN,
        FLOW_RANDOM,
        FLOW_TWO_OF_THREE,
        FLOW_ONE_OF_FOUR
    } flow_style_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [15:0]          s_axis_tdata = '0;   // column[5:0], row[9:6], zero fill
    logic                 s_axis_tuser = 1'b0; // req_type
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [23:0]          m_axis_tdata;        // red[7:0], green[15:8], blue[23:16]
    logic                 m_axis_tuser;        // lit
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [23:0]          cfg_data = '0;

    int mismatch_count;
    int words_pending;
    int burst_left = 0;
    bit hold_request = 1'b0;

    scrolling_sprite_row_pixel_gen_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    pixel_word_checker pixel_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tuser   (m_axis_tuser),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .words_pending  (words_pending)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // overall time limit
    initial
    begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end

    // receiver: changing stall patterns, plus a long hold-off on request
    initial
    begin : receiver
        int          hold_left;
        int          style_left;
        int          beat;
        flow_style_t style;
        hold_left  = 0;
        style_left = 0;
        beat       = 0;
        style      = FLOW_OPEN;
        forever begin
            @(posedge clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_OFF;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else begin
                if (style_left == 0) begin
                    style      = flow_style_t'($urandom_range(0, 3));
                    style_left = $urandom_range(16, 80);
                end
                style_left--;
                beat++;
                case (style)
                    FLOW_OPEN:         m_axis_tready <= 1'b1;
                    FLOW_RANDOM:       m_axis_tready <= 1'($urandom_range(0, 1));
                    FLOW_TWO_OF_THREE: m_axis_tready <= (beat % 3) != 0;
                    default:           m_axis_tready <= (beat % 4) == 0;
                endcase
            end
        end
    end

    // offer one input word, in bursts with random gaps between them
    task automatic send_word(req_type_t kind, logic [5:0] col, logic [3:0] row);
        int gap;
        if (burst_left == 0) begin
            gap        = $urandom_range(0, 5);
            burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {6'd0, row, col};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        burst_left--;
    endtask

    task automatic send_query(int col, int row);
        send_word(REQ_QUERY, 6'(col), 4'(row));
    endtask

    task automatic send_tick();
        send_word(REQ_TICK, 6'($urandom), 4'($urandom));
    endtask

    // stop offering and let every pending word and tick drain out
    task automatic go_idle();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (words_pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [23:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    function automatic logic [23:0] pick_period();
        case ($urandom_range(0, 9))
            0:       return 24'd0;
            1:       return 24'd255;
            2:       return 24'($urandom_range(1, 255));
            default: return 24'($urandom & 32'hFFFF00) | 24'($urandom_range(1, 4));
        endcase
    endfunction

    function automatic logic [23:0] pick_colour();
        case ($urandom_range(0, 5))
            0:       return 24'h000000;
            1:       return 24'hFFFFFF;
            default: return 24'($urandom);
        endcase
    endfunction

    // new register settings for one random pass
    task automatic new_settings(int pass);
        go_idle();
        if (pass == 0) begin
            // all maxima
            write_reg(CFG_MODE, 24'hFFFFFF);
            write_reg(CFG_SCROLL_PERIOD, 24'd255);
            write_reg(CFG_ANIM_PERIOD, 24'd255);
            write_reg(CFG_MONO_COLOR, 24'hFFFFFF);
            write_reg(CFG_CHOMPER_COLOR, 24'hFFFFFF);
            write_reg(CFG_GHOST_A_COLOR, 24'hFFFFFF);
            write_reg(CFG_GHOST_B_COLOR, 24'hFFFFFF);
            write_reg(CFG_DOT_COLOR, 24'hFFFFFF);
        end
        else if (pass == 1) begin
            // all minima, lit pixels in black
            write_reg(CFG_MODE, 24'd0);
            write_reg(CFG_SCROLL_PERIOD, 24'd1);
            write_reg(CFG_ANIM_PERIOD, 24'd1);
            write_reg(CFG_MONO_COLOR, 24'd0);
            write_reg(CFG_CHOMPER_COLOR, 24'd0);
            write_reg(CFG_GHOST_A_COLOR, 24'd0);
            write_reg(CFG_GHOST_B_COLOR, 24'd0);
            write_reg(CFG_DOT_COLOR, 24'd0);
        end
        else begin
            write_reg(CFG_MODE, 24'($urandom));
            if ($urandom_range(0, 2) != 0) write_reg(CFG_SCROLL_PERIOD, pick_period());
            if ($urandom_range(0, 2) != 0) write_reg(CFG_ANIM_PERIOD, pick_period());
            if ($urandom_range(0, 2) != 0) write_reg(CFG_MONO_COLOR, pick_colour());
            if ($urandom_range(0, 2) != 0) write_reg(CFG_CHOMPER_COLOR, pick_colour());
            if ($urandom_range(0, 2) != 0) write_reg(CFG_GHOST_A_COLOR, pick_colour());
            if ($urandom_range(0, 2) != 0) write_reg(CFG_GHOST_B_COLOR, pick_colour());
            if ($urandom_range(0, 2) != 0) write_reg(CFG_DOT_COLOR, pick_colour());
            if ($urandom_range(0, 3) == 0)
                write_reg(CFG_IDX_W'($urandom_range(REG_COUNT, (1 << CFG_IDX_W) - 1)),
                          24'($urandom));
        end
        cfg_valid <= 1'b0;
    endtask

    // random traffic: scan runs along the sprite band, single pixels, ticks
    task automatic pixel_traffic(int count);
        int sent;
        int pick;
        int run;
        int col;
        int row;
        sent = 0;
        while (sent < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 15) begin
                send_tick();
                sent++;
            end
            else if (pick < 35) begin
                row = $urandom_range(BAND_TOP, BAND_TOP + SPR_H - 1);
                col = $urandom_range(0, GRID_COLS - 1);
                run = $urandom_range(8, 24);
                for (int i = 0; i < run; i++)
                    send_query(col + i, row);
                sent += run;
            end
            else if (pick < 90) begin
                send_query($urandom_range(0, GRID_COLS - 1),
                           $urandom_range(BAND_TOP, BAND_TOP + SPR_H - 1));
                sent++;
            end
            else begin
                send_query($urandom_range(0, GRID_COLS - 1), $urandom_range(0, GRID_ROWS - 1));
                sent++;
            end
        end
    endtask

    // stimulus and verdict
    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: grid corners, dots, chomper mouth, both ghosts
        send_query(0, 0);
        send_query(GRID_COLS - 1, GRID_ROWS - 1);
        send_query(10, BAND_TOP + 3);
        send_query(10, BAND_TOP + 2);
        send_query(0, BAND_TOP + 3);
        send_query(3, BAND_TOP + 3);
        send_query(20, BAND_TOP);
        send_query(29, BAND_TOP + 6);
        send_tick();
        send_query(29, BAND_TOP + 6);

        // colour per element, reverse scroll, zero periods, unused index
        go_idle();
        write_reg(CFG_MODE, 24'd3);
        write_reg(CFG_SCROLL_PERIOD, 24'd0);
        write_reg(CFG_ANIM_PERIOD, 24'd0);
        write_reg(CFG_MONO_COLOR, 24'd0);
        write_reg(CFG_CHOMPER_COLOR, 24'hFFFFFF);
        write_reg(CFG_GHOST_A_COLOR, 24'h000000);
        write_reg(CFG_GHOST_B_COLOR, 24'hFFFFFF);
        write_reg(CFG_DOT_COLOR, 24'h123456);
        write_reg(CFG_IDX_W'(REG_COUNT), 24'hABCDEF);
        write_reg(CFG_IDX_W'((1 << CFG_IDX_W) - 1), 24'h000001);
        cfg_valid <= 1'b0;
        send_tick();
        send_query(1, BAND_TOP + 3);
        send_query(11, BAND_TOP + 3);
        send_query(19, BAND_TOP);
        send_query(28, BAND_TOP + 6);

        // long periods, then lowered below the running counts
        go_idle();
        write_reg(CFG_MODE, 24'd0);
        write_reg(CFG_SCROLL_PERIOD, 24'd255);
        write_reg(CFG_ANIM_PERIOD, 24'd255);
        cfg_valid <= 1'b0;
        repeat (4) send_tick();
        go_idle();
        write_reg(CFG_SCROLL_PERIOD, 24'd2);
        write_reg(CFG_ANIM_PERIOD, 24'd2);
        cfg_valid <= 1'b0;
        send_tick();
        send_query(0, BAND_TOP + 3);

        // random passes, two of them under a long receiver hold-off
        for (int pass = 0; pass < RAND_PASSES; pass++) begin
            new_settings(pass);
            if (pass == 2 || pass == 4)
                hold_request = 1'b1;
            pixel_traffic(RAND_WORDS);
        end

        go_idle();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0 && words_pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/ssrpg_pkg.sv
rtl/ssrpg_pixel.sv
rtl/scrolling_sprite_row_pixel_gen_unit.sv
tb/pixel_word_checker.sv
tb/scrolling_sprite_row_pixel_gen_unit_test.sv
